/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the console RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 4;

  // Fixed field widths of the item streams.
  localparam int OP_W      = 2;
  localparam int CH_W      = 8;
  localparam int IDX_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int POS_W     = 11;
  localparam int COLOR_W   = 8;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Character codes with special handling.
  localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CH_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CH_W-1:0] CH_NULL    = 8'd0;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_TAB
  } ch_kind_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_CR,
    CUR_NEWLINE,
    CUR_ADVANCE
  } cur_cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_SCROLL_COPY,
    ST_SCROLL_FLUSH,
    ST_SCROLL_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     ptr_clr;
    logic     copy_rd;
    logic     blank_wr;
    logic     init_wr;
    logic     wr_char;
    logic     tab_dec;
    logic     out_load;
    cur_cmd_e cur;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    ch_kind_e        kind;
    logic            at_last_col;
    logic            at_last_row;
    logic            tab_one;
    logic            tab_zero;
    logic            ptr_last_copy;
    logic            ptr_last;
    logic            out_free;
  } dp_status_t;

endpackage

/* hdl/tcw_dpath.sv */
// ----------------------------------------------------------------------------
// tcw_dpath
// Screen memories, cursor, sweep pointer, tab counter and result register.
// ----------------------------------------------------------------------------
module tcw_dpath #(
  parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::dp_cmd_t              cmd_i,
  output tcw_pkg::dp_status_t           status_o,
  input  logic [tcw_pkg::OP_W-1:0]      op_i,
  input  logic [tcw_pkg::CH_W-1:0]      ch_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tcw_pkg::COL_OUT_W-1:0] cursor_col_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row_o,
  output logic [tcw_pkg::POS_W-1:0]     cursor_pos_o,
  output logic [tcw_pkg::CH_W-1:0]      cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0]   cell_color_o
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_STOP);
  localparam int CNT_W  = $clog2(TAB_STOP + 1);

  logic [CH_W-1:0]    chars_mem  [CELLS];
  logic [COLOR_W-1:0] colors_mem [CELLS];

  logic [OP_W-1:0]    op_q;
  logic [CH_W-1:0]    ch_q;
  logic [IDX_W-1:0]   idx_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [CNT_W-1:0]   tab_cnt_q;
  logic [ADDR_W-1:0]  ptr_q;
  logic [COLOR_W-1:0] blank_q;
  logic               pend_q;
  logic [ADDR_W-1:0]  pend_addr_q;
  logic [CH_W-1:0]    rd_char_q;
  logic [COLOR_W-1:0] rd_color_q;
  logic               out_valid_q;

  ch_kind_e           kind;
  logic               at_last_col, at_last_row;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we, color_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CH_W-1:0]    wr_char;
  logic [COLOR_W-1:0] wr_color;
  logic               in_range;
  logic               out_free;

  always_comb begin
    unique case (ch_q)
      CH_NEWLINE: kind = KIND_NEWLINE;
      CH_RETURN:  kind = KIND_RETURN;
      CH_TAB:     kind = KIND_TAB;
      default:    kind = KIND_PLAIN;
    endcase
  end

  assign at_last_col = (col_q == COL_W'(COLUMNS - 1));
  assign at_last_row = (row_q == ROW_W'(ROWS - 1));
  assign cur_addr    = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign in_range    = (32'(idx_q) < 32'(CELLS));
  assign out_free    = !out_valid_q || out_ready_i;

  assign status_o.op            = op_q;
  assign status_o.kind          = kind;
  assign status_o.at_last_col   = at_last_col;
  assign status_o.at_last_row   = at_last_row;
  assign status_o.tab_one       = (tab_cnt_q == CNT_W'(1));
  assign status_o.tab_zero      = (tab_cnt_q == '0);
  assign status_o.ptr_last_copy = (ptr_q == ADDR_W'(CELLS - COLUMNS - 1));
  assign status_o.ptr_last      = (ptr_q == ADDR_W'(CELLS - 1));
  assign status_o.out_free      = out_free;

  // Input latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      ch_q  <= ch_i;
      idx_q <= cell_index_i;
    end
  end

  // Cursor update. A wrap or line feed on the last row keeps the row, since
  // the scroll that follows moves the whole screen up instead.
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    unique case (cmd_i.cur)
      CUR_HOLD: begin
      end
      CUR_HOME: begin
        col_d   = '0;
        row_d   = '0;
        phase_d = '0;
      end
      CUR_CR: begin
        col_d   = '0;
        phase_d = '0;
      end
      CUR_NEWLINE: begin
        col_d   = '0;
        phase_d = '0;
        if (!at_last_row) begin
          row_d = row_q + ROW_W'(1);
        end
      end
      CUR_ADVANCE: begin
        if (at_last_col) begin
          col_d   = '0;
          phase_d = '0;
          if (!at_last_row) begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d   = col_q + COL_W'(1);
          phase_d = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      tab_cnt_q   <= '0;
      ptr_q       <= '0;
      blank_q     <= RESET_COLOR;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      if (cmd_i.latch) begin
        tab_cnt_q <= CNT_W'(TAB_STOP) - CNT_W'(phase_q);
      end else if (cmd_i.tab_dec && (tab_cnt_q != '0)) begin
        tab_cnt_q <= tab_cnt_q - CNT_W'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.copy_rd || cmd_i.blank_wr || cmd_i.init_wr) begin
        ptr_q <= ptr_q + ADDR_W'(1);
      end
      if (cfg_we_i) begin
        blank_q <= cfg_wdata_i;
      end
      pend_q <= cmd_i.copy_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= ptr_q;
  end

  // A scroll reads one row ahead and writes the cell back in the following cycle.
  assign rd_addr = cmd_i.copy_rd ? (ptr_q + ADDR_W'(COLUMNS)) : ADDR_W'(idx_q);

  always_comb begin
    mem_we   = 1'b0;
    color_we = 1'b0;
    wr_addr  = ptr_q;
    wr_char  = CH_NULL;
    wr_color = blank_q;
    priority if (pend_q) begin
      mem_we   = 1'b1;
      color_we = 1'b1;
      wr_addr  = pend_addr_q;
      wr_char  = rd_char_q;
      wr_color = rd_color_q;
    end else if (cmd_i.blank_wr) begin
      mem_we   = 1'b1;
      color_we = 1'b1;
    end else if (cmd_i.init_wr) begin
      mem_we   = 1'b1;
      color_we = 1'b1;
      wr_color = RESET_COLOR;
    end else if (cmd_i.wr_char) begin
      mem_we  = 1'b1;
      wr_addr = cur_addr;
      wr_char = (kind == KIND_TAB) ? CH_SPACE : ch_q;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chars_mem[wr_addr] <= wr_char;
    end
    if (mem_we && color_we) begin
      colors_mem[wr_addr] <= wr_color;
    end
    rd_char_q  <= chars_mem[rd_addr];
    rd_color_q <= colors_mem[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cursor_col_o <= COL_OUT_W'(col_q);
      cursor_row_o <= ROW_OUT_W'(row_q);
      cursor_pos_o <= POS_W'(cur_addr);
      if ((op_q == OP_READ) && in_range) begin
        cell_char_o  <= rd_char_q;
        cell_color_o <= rd_color_q;
      end else begin
        cell_char_o  <= CH_NULL;
        cell_color_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `include "assert_macros.svh"

  `ASSERT_SAME(a_cursor_in_range, clk_i, rst_ni, 1'b1, (32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)), "cursor left the screen")
  `ASSERT_SAME(a_copy_write_alone, clk_i, rst_ni, pend_q, !(cmd_i.blank_wr || cmd_i.init_wr || cmd_i.wr_char), "scroll copy write collides with another write")
  `ASSERT_SAME(a_tab_has_spaces, clk_i, rst_ni, cmd_i.wr_char && (kind == KIND_TAB), tab_cnt_q != '0, "tab space written with no spaces left")

endmodule

/* hdl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer of the text console writer.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;
  logic   wrap_scroll;

  assign in_fire     = in_valid_i && in_ready_o;
  assign wrap_scroll = status_i.at_last_col && status_i.at_last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.ptr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status_i.op == OP_PUT) begin
          unique case (status_i.kind)
            KIND_NEWLINE: state_d = status_i.at_last_row ? ST_SCROLL_COPY : ST_DONE;
            KIND_RETURN:  state_d = ST_DONE;
            default:      state_d = ST_PUT;
          endcase
        end else if (status_i.op == OP_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PUT: begin
        if (wrap_scroll) begin
          state_d = ST_SCROLL_COPY;
        end else if ((status_i.kind == KIND_TAB) && !status_i.tab_one) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL_COPY: begin
        if (status_i.ptr_last_copy) state_d = ST_SCROLL_FLUSH;
      end
      ST_SCROLL_FLUSH: begin
        state_d = ST_SCROLL_BLANK;
      end
      ST_SCROLL_BLANK: begin
        if (status_i.ptr_last) begin
          if ((status_i.kind == KIND_TAB) && !status_i.tab_zero) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        if (status_i.ptr_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.cur  = CUR_HOLD;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_DISPATCH: begin
        if (status_i.op == OP_PUT) begin
          unique case (status_i.kind)
            KIND_NEWLINE: begin
              cmd_o.cur     = CUR_NEWLINE;
              cmd_o.ptr_clr = status_i.at_last_row;
            end
            KIND_RETURN: cmd_o.cur = CUR_CR;
            default: begin
            end
          endcase
        end else if (status_i.op == OP_CLEAR) begin
          cmd_o.cur     = CUR_HOME;
          cmd_o.ptr_clr = 1'b1;
        end
      end
      ST_PUT: begin
        cmd_o.wr_char = 1'b1;
        cmd_o.tab_dec = 1'b1;
        cmd_o.cur     = CUR_ADVANCE;
        cmd_o.ptr_clr = wrap_scroll;
      end
      ST_SCROLL_COPY: begin
        cmd_o.copy_rd = 1'b1;
      end
      ST_SCROLL_FLUSH: begin
      end
      ST_SCROLL_BLANK, ST_CLEAR: begin
        cmd_o.blank_wr = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, in_fire, state_q == ST_DISPATCH, "accepted item not dispatched")
  `ASSERT_SAME(a_flush_after_copy, clk_i, rst_ni, state_q == ST_SCROLL_FLUSH, $past(state_q) == ST_SCROLL_COPY, "scroll flush without copy")
  `ASSERT_NEXT(a_load_returns_idle, clk_i, rst_ni, cmd_o.out_load, state_q == ST_IDLE, "result load did not end the item")

endmodule

/* hdl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: COLUMNS x ROWS cells of character and color,
// with cursor, wrap, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken only after the result of
// the last is registered. A scroll and a clear sweep the screen memory cell
// by cell through its single write port. After reset the screen is swept with
// s_axis_tready low.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: blank color register, taken at any time.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] ch, [18:8] cell_index, [23:19] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [6:0] cursor_col, [11:7] cursor_row,
                                     // [22:12] cursor_pos, [30:23] cell_char,
                                     // [38:31] cell_color, [39] zero
);
  import tcw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [POS_W-1:0]     cursor_pos;
  logic [CH_W-1:0]      cell_char;
  logic [COLOR_W-1:0]   cell_color;

  // The controller walks each operation through its states and drives the
  // datapath with one command word per cycle.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the screen memories, the cursor and the result
  // register that decouples the output side.
  tcw_dpath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (s_axis_tuser),
    .ch_i         (s_axis_tdata[7:0]),
    .cell_index_i (s_axis_tdata[18:8]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .cursor_col_o (cursor_col),
    .cursor_row_o (cursor_row),
    .cursor_pos_o (cursor_pos),
    .cell_char_o  (cell_char),
    .cell_color_o (cell_color)
  );

  // Fields packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {1'b0, cell_color, cell_char, cursor_pos, cursor_row, cursor_col};

endmodule

/* verif/text_console_writer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the character-cell text console. A scoreboard keeps
// its own copy of the screen, the cursor and the blank color. It predicts the
// result of every accepted item and compares it field by field with what the
// console returns. Stimulus starts with a short directed list of corner cases.
// Random phases follow under several blank colors, with text bursts, line
// feeds, tabs, reads, clears and unused operations. Both stream sides idle at
// random, and one phase holds the result side off long enough to back-pressure
// the input.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  import tcw_pkg::*;

  // Screen geometry of the default build.
  localparam int COLUMNS  = DEF_COLUMNS;
  localparam int ROWS     = DEF_ROWS;
  localparam int TAB_STOP = DEF_TAB_STOP;
  localparam int CELLS    = COLUMNS * ROWS;

  // The fourth operation code is unused by the console.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Run limits.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 2100;  // a bit more than one scroll or clear
  localparam int REPORT_LIMIT = 10;

  // One input item and one result item, in terms of the console's fields.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] cell_index;
  } console_cmd_t;

  // Laid out like the result bus: the last member sits in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0]   tint;
    logic [CH_W-1:0]      glyph;
    logic [POS_W-1:0]     pos;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } console_view_t;

  // Clock, reset and the console's ports. Every input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] ch, [18:8] cell_index, [23:19] zero
  logic [1:0]  s_axis_tuser = '0;  // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // [6:0] cursor_col, [11:7] cursor_row,
                                   // [22:12] cursor_pos, [30:23] cell_char,
                                   // [38:31] cell_color, [39] zero

  // Items waiting to be sent, and results that the console still owes us.
  console_cmd_t  pending_cmds[$];
  console_view_t owed_views[$];

  // Scoreboard copy of the console state.
  logic [CH_W-1:0]    glyph_mem[CELLS];
  logic [COLOR_W-1:0] tint_mem[CELLS];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] blank_tint;

  // Idle rate in percent for both sides, and the long hold-off requests.
  int unsigned idle_pct = 23;
  int unsigned hold_requests = 0;
  int unsigned holds_served;
  int unsigned hold_left;

  // Bookkeeping.
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned scrolls_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned reads_seen = 0;
  int unsigned tabs_seen = 0;

  text_console_writer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model of the console.
  // --------------------------------------------------------------------------

  // Moves every line up by one, blanks the bottom line and pulls the cursor up.
  function automatic void scroll_screen();
    for (int i = 0; i + COLUMNS < CELLS; i++) begin
      glyph_mem[i] = glyph_mem[i + COLUMNS];
      tint_mem[i]  = tint_mem[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      glyph_mem[i] = CH_NULL;
      tint_mem[i]  = blank_tint;
    end
    if (cur_row > 0) cur_row--;
    scrolls_seen++;
  endfunction

  // Wraps a column past the right edge, then scrolls a line past the bottom.
  function automatic void settle_cursor();
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  // An ordinary character replaces only the character byte; the color stays.
  function automatic void place_glyph(logic [CH_W-1:0] c);
    if (cur_col < COLUMNS && cur_row < ROWS) glyph_mem[cur_row * COLUMNS + cur_col] = c;
    cur_col++;
    settle_cursor();
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      glyph_mem[i] = CH_NULL;
      tint_mem[i]  = blank_tint;
    end
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Applies one command to the model and returns the result it must produce.
  function automatic console_view_t run_command(console_cmd_t cmd);
    console_view_t view;
    int unsigned   spaces;
    view = '0;
    case (cmd.op)
      OP_PUT: begin
        case (cmd.ch)
          CH_NEWLINE: begin
            cur_col = 0;
            cur_row++;
            settle_cursor();
          end
          CH_RETURN: cur_col = 0;
          CH_TAB: begin
            // Each space of a tab wraps and scrolls on its own.
            spaces = TAB_STOP - (cur_col % TAB_STOP);
            for (int k = 0; k < spaces; k++) place_glyph(CH_SPACE);
            tabs_seen++;
          end
          default: place_glyph(cmd.ch);
        endcase
      end
      OP_CLEAR: begin
        blank_screen();
        clears_seen++;
      end
      OP_READ: begin
        // Indexes past the screen read back as zero.
        if (cmd.cell_index < CELLS) begin
          view.glyph = glyph_mem[cmd.cell_index];
          view.tint  = tint_mem[cmd.cell_index];
        end
        reads_seen++;
      end
      default: ;  // The unused code only reports the cursor.
    endcase
    view.col = COL_OUT_W'(cur_col);
    view.row = ROW_OUT_W'(cur_row);
    view.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return view;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building.
  // --------------------------------------------------------------------------

  function automatic void add_cmd(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                  logic [IDX_W-1:0] cell_index);
    console_cmd_t cmd;
    cmd.op = op;
    cmd.ch = ch;
    cmd.cell_index = cell_index;
    pending_cmds.push_back(cmd);
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(2047));
  endfunction

  // Reads favor the bottom line, where scrolled-in blanks land, and the top
  // line, where text starts after a clear; a few fall past the screen.
  function automatic logic [IDX_W-1:0] pick_cell();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 4) return IDX_W'($urandom_range(CELLS - 1));
    if (roll < 7) return IDX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS));
    if (roll < 9) return IDX_W'($urandom_range(COLUMNS - 1));
    return IDX_W'($urandom_range(2047, CELLS));
  endfunction

  // Builds a random phase out of text bursts and single control items.
  // line_pct sets how often a line feed is chosen, and so how soon the
  // cursor reaches the bottom and every further line feed scrolls.
  function automatic void queue_random_phase(int unsigned count, int unsigned line_pct);
    int unsigned added;
    int unsigned roll;
    int unsigned burst;
    logic [CH_W-1:0] c;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(99);
      if (roll < line_pct) begin
        add_cmd(OP_PUT, CH_NEWLINE, any_index());
        added++;
      end else if (roll < line_pct + 45) begin
        // A burst of text; now and then any byte at all gets in.
        burst = $urandom_range(16, 1);
        for (int k = 0; k < burst; k++) begin
          c = ($urandom_range(7) == 0) ? CH_W'($urandom_range(255))
                                       : CH_W'($urandom_range(126, 32));
          add_cmd(OP_PUT, c, any_index());
        end
        added += burst;
      end else if (roll < line_pct + 55) begin
        add_cmd(OP_PUT, CH_TAB, any_index());
        added++;
      end else if (roll < line_pct + 60) begin
        add_cmd(OP_PUT, CH_RETURN, any_index());
        added++;
      end else if (roll < line_pct + 62) begin
        add_cmd(OP_CLEAR, CH_W'($urandom_range(255)), any_index());
        added++;
      end else if (roll < line_pct + 64) begin
        add_cmd(OP_SPARE, CH_W'($urandom_range(255)), any_index());
        added++;
      end else begin
        add_cmd(OP_READ, CH_W'($urandom_range(255)), pick_cell());
        added++;
      end
    end
  endfunction

  // Writes the blank color while the console is idle.
  task automatic write_blank_color(logic [COLOR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    blank_tint = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // The sender stops until every item has gone out and every result is in.
  task automatic wait_for_drain();
    do @(negedge clk_i); while (pending_cmds.size() != 0 || owed_views.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers the oldest pending item, keeps it steady while stalled,
  // and hands each accepted item to the scoreboard.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_PUT;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed_views.push_back(run_command(pending_cmds.pop_front()));
        items_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // A stalled item stays on the bus unchanged.
      end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, pending_cmds[0].cell_index, pending_cmds[0].ch};
        s_axis_tuser  <= pending_cmds[0].op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      holds_served  <= 0;
      hold_left     <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    console_view_t got;
    console_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[38:0];
      results_checked++;
      if (owed_views.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result: col %0d row %0d pos %0d char %02h color %02h",
                   got.col, got.row, got.pos, got.glyph, got.tint);
      end else begin
        want = owed_views.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Result %0d mismatch: expected col %0d row %0d pos %0d char %02h color %02h",
                     results_checked, want.col, want.row, want.pos, want.glyph, want.tint);
            $display("  got col %0d row %0d pos %0d char %02h color %02h",
                     got.col, got.row, got.pos, got.glyph, got.tint);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, owed_views.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    // The model starts from the reset state of the console.
    blank_tint = RESET_COLOR;
    blank_screen();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases, run with the reset blank color. The console
    // sweeps its screen memory after reset, so the first item simply waits.
    @(negedge clk_i);
    add_cmd(OP_READ, CH_NULL, '0);             // untouched cell at reset
    add_cmd(OP_READ, 8'hFF, IDX_W'(CELLS - 1)); // last cell at reset
    add_cmd(OP_PUT, 8'h41, '0);
    add_cmd(OP_PUT, 8'hFF, 11'h7FF);           // top character code
    add_cmd(OP_PUT, CH_NULL, '0);              // zero byte is an ordinary write
    add_cmd(OP_READ, CH_NULL, '0);             // written character, kept color
    add_cmd(OP_READ, CH_NULL, 11'd1);
    add_cmd(OP_PUT, CH_TAB, '0);               // one space up to column four
    add_cmd(OP_PUT, CH_TAB, '0);               // a whole tab width from a stop
    add_cmd(OP_READ, CH_NULL, 11'd3);
    add_cmd(OP_PUT, CH_RETURN, '0);
    add_cmd(OP_PUT, CH_RETURN, '0);            // return at column zero
    add_cmd(OP_PUT, CH_NEWLINE, '0);
    add_cmd(OP_SPARE, 8'hFF, 11'h7FF);         // unused code, all bits high
    add_cmd(OP_SPARE, CH_NULL, '0);
    add_cmd(OP_READ, CH_NULL, IDX_W'(CELLS));  // first index past the screen
    add_cmd(OP_READ, CH_NULL, 11'h7FF);        // largest index
    add_cmd(OP_PUT, 8'h80, '0);
    add_cmd(OP_CLEAR, 8'hFF, 11'h7FF);
    add_cmd(OP_READ, CH_NULL, '0);             // cleared cell
    add_cmd(OP_PUT, 8'h7E, '0);
    wait_for_drain();

    // Darkest blank color, moderate line feeds.
    write_blank_color(8'h00);
    @(negedge clk_i);
    queue_random_phase(68, 12);
    wait_for_drain();

    // Brightest blank color, many line feeds so the screen scrolls often,
    // and a long stretch with no idling on either side.
    write_blank_color(8'hFF);
    @(negedge clk_i);
    idle_pct = 0;
    queue_random_phase(68, 30);
    wait_for_drain();

    // Random blank color; the result side holds off for a long time while
    // the sender keeps offering, so the console backs up into its input.
    write_blank_color(COLOR_W'($urandom_range(254, 1)));
    @(negedge clk_i);
    idle_pct = 23;
    queue_random_phase(68, 20);
    hold_requests++;
    wait_for_drain();

    // Back to the reset color for the last phase.
    write_blank_color(RESET_COLOR);
    @(negedge clk_i);
    queue_random_phase(68, 15);
    wait_for_drain();

    // Nothing is owed any more; give a stray result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_views.size() != 0) mismatches++;

    $display("Sent %0d items: %0d reads, %0d tabs, %0d clears, %0d scrolls, five color phases.",
             items_sent, reads_seen, tabs_seen, clears_seen, scrolls_seen);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
